@@ rtl/rqr_pkg.sv @@
// Shared types and constants for the relative quaternion to rotation block.
// No dependencies.
package rqr_pkg;
  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    quat_t cur;
    quat_t rf;
    logic  held;
  } job_t;

  localparam logic [1:0] REG_W = 2'd0;
  localparam logic [1:0] REG_X = 2'd1;
  localparam logic [1:0] REG_Y = 2'd2;
  localparam logic [1:0] REG_Z = 2'd3;
endpackage

@@ rtl/rqr_front.sv @@
// Front part: accepts a sample, snapshots the reference and tags the held case.
// Two-entry job queue toward the back part. Depends on rqr_pkg.
module rqr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  rqr_pkg::quat_t cur,
  input  rqr_pkg::quat_t rf,
  output logic           job_valid,
  input  logic           job_take,
  output rqr_pkg::job_t  job
);
  rqr_pkg::job_t q [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;
  rqr_pkg::job_t in_job;

  assign full      = (count == 2'd2);
  assign job_valid = (count != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = job_take && job_valid;
  assign job       = q[rd_ptr];

  always_comb begin
    in_job.cur  = cur;
    in_job.rf   = rf;
    in_job.held = (rf.w == 16'sd0);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_job;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

@@ rtl/rqr_back.sv @@
// Back part: sequencer computing product, norm, normalization and matrix rows.
// Shares one multiplier, bit-serial square root and divider. Depends on rqr_pkg.
module rqr_back #(
  parameter int FRAC_BITS = 14
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_take,
  input  rqr_pkg::job_t  job,
  output logic           empty,
  input  logic           pop,
  output logic [1:0]     row_index,
  output logic [15:0]    col_a,
  output logic [15:0]    col_b,
  output logic [15:0]    col_c,
  output rqr_pkg::quat_t rel,
  output logic           held_flag,
  output logic           last_row
);
  localparam logic signed [39:0] LIM =
    (FRAC_BITS >= 15) ? 40'sd32767 : (40'sd1 <<< FRAC_BITS);
  localparam logic signed [63:0] ONE2 = 64'sd1 <<< (2 * FRAC_BITS);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_PROD = 10'b0000000010,
    S_SHFT = 10'b0000000100,
    S_SQR  = 10'b0000001000,
    S_ROOT = 10'b0000010000,
    S_DIV  = 10'b0000100000,
    S_MTX  = 10'b0001000000,
    S_ROW  = 10'b0010000000,
    S_OUT  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state;
  rqr_pkg::job_t jb;
  rqr_pkg::quat_t held;
  logic signed [35:0] p [4];
  logic [33:0] mag [4];
  logic [5:0]  cnt;
  logic [1:0]  idx;
  logic [1:0]  tix;
  logic [63:0] n2;
  logic [63:0] rem_s;
  logic [31:0] root;
  logic [33:0] dnum;
  logic [65:0] drem;
  logic [51:0] dq;
  logic signed [63:0] acc [9];
  logic [3:0]  mi;
  logic [1:0]  row;
  logic signed [15:0] ma;
  logic signed [15:0] mb;
  logic signed [15:0] mc;
  logic        out_valid;

  logic signed [15:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [31:0] mul_r;
  assign mul_r = mul_a * mul_b;

  // product term selection: term tix of part idx
  logic signed [15:0] cterm;
  logic signed [15:0] rterm;
  logic               tneg;
  always_comb begin
    cterm = jb.cur.w;
    rterm = jb.rf.w;
    tneg  = 1'b0;
    unique case ({idx, tix})
      4'h0: begin cterm = jb.cur.w; rterm = jb.rf.w; tneg = 1'b0; end
      4'h1: begin cterm = jb.cur.x; rterm = jb.rf.x; tneg = 1'b0; end
      4'h2: begin cterm = jb.cur.y; rterm = jb.rf.y; tneg = 1'b0; end
      4'h3: begin cterm = jb.cur.z; rterm = jb.rf.z; tneg = 1'b0; end
      4'h4: begin cterm = jb.cur.w; rterm = jb.rf.x; tneg = 1'b1; end
      4'h5: begin cterm = jb.cur.x; rterm = jb.rf.w; tneg = 1'b0; end
      4'h6: begin cterm = jb.cur.y; rterm = jb.rf.z; tneg = 1'b1; end
      4'h7: begin cterm = jb.cur.z; rterm = jb.rf.y; tneg = 1'b0; end
      4'h8: begin cterm = jb.cur.w; rterm = jb.rf.y; tneg = 1'b1; end
      4'h9: begin cterm = jb.cur.x; rterm = jb.rf.z; tneg = 1'b0; end
      4'hA: begin cterm = jb.cur.y; rterm = jb.rf.w; tneg = 1'b0; end
      4'hB: begin cterm = jb.cur.z; rterm = jb.rf.x; tneg = 1'b1; end
      4'hC: begin cterm = jb.cur.w; rterm = jb.rf.z; tneg = 1'b1; end
      4'hD: begin cterm = jb.cur.x; rterm = jb.rf.y; tneg = 1'b1; end
      4'hE: begin cterm = jb.cur.y; rterm = jb.rf.x; tneg = 1'b0; end
      default: begin cterm = jb.cur.z; rterm = jb.rf.w; tneg = 1'b0; end
    endcase
  end

  // matrix term schedule: entry mi, term tix (0..1), factor pair and sign
  logic signed [15:0] fa;
  logic signed [15:0] fb;
  logic               msub;
  always_comb begin
    fa = held.y;
    fb = held.y;
    msub = 1'b1;
    unique case ({mi, tix[0]})
      5'd0:  begin fa = held.y; fb = held.y; msub = 1'b1; end
      5'd1:  begin fa = held.z; fb = held.z; msub = 1'b1; end
      5'd2:  begin fa = held.x; fb = held.y; msub = 1'b0; end
      5'd3:  begin fa = held.z; fb = held.w; msub = 1'b1; end
      5'd4:  begin fa = held.x; fb = held.z; msub = 1'b0; end
      5'd5:  begin fa = held.y; fb = held.w; msub = 1'b0; end
      5'd6:  begin fa = held.x; fb = held.y; msub = 1'b0; end
      5'd7:  begin fa = held.z; fb = held.w; msub = 1'b0; end
      5'd8:  begin fa = held.x; fb = held.x; msub = 1'b1; end
      5'd9:  begin fa = held.z; fb = held.z; msub = 1'b1; end
      5'd10: begin fa = held.y; fb = held.z; msub = 1'b0; end
      5'd11: begin fa = held.x; fb = held.w; msub = 1'b1; end
      5'd12: begin fa = held.x; fb = held.z; msub = 1'b0; end
      5'd13: begin fa = held.y; fb = held.w; msub = 1'b1; end
      5'd14: begin fa = held.y; fb = held.z; msub = 1'b0; end
      5'd15: begin fa = held.x; fb = held.w; msub = 1'b0; end
      5'd16: begin fa = held.x; fb = held.x; msub = 1'b1; end
      default: begin fa = held.y; fb = held.y; msub = 1'b1; end
    endcase
  end

  always_comb begin
    mul_a = fa;
    mul_b = fb;
    if (state == S_PROD) begin
      mul_a = cterm;
      mul_b = rterm;
    end
  end

  // max magnitude for shift
  logic [33:0] mx;
  always_comb begin
    mx = mag[0];
    for (int i = 1; i < 4; i++) begin
      if (mag[i] > mx) mx = mag[i];
    end
  end

  // squaring of a 30-bit magnitude in two 15-bit halves is overkill; use a
  // 32x32 product per cycle
  logic [31:0] sq_in;
  logic [63:0] sq_out;
  assign sq_in  = mag[idx][31:0];
  assign sq_out = sq_in * sq_in;

  // square root step
  logic [65:0] rem_sh;
  logic [33:0] trial;
  assign rem_sh = {rem_s, n2[63:62]};
  assign trial  = {root, 2'b01};

  // divider step
  logic [65:0] dsh;
  assign dsh = {drem[64:0], dq[51]};

  // rounding of a matrix accumulator
  logic signed [63:0] rnd_v;
  logic [63:0] rnd_mag;
  logic [63:0] rnd_r;
  logic signed [63:0] rnd_s;
  logic signed [15:0] rnd_o;
  always_comb begin
    rnd_v   = acc[mi];
    rnd_mag = rnd_v[63] ? 64'(-rnd_v) : 64'(rnd_v);
    rnd_r   = (rnd_mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    rnd_s   = rnd_v[63] ? -$signed(rnd_r) : $signed(rnd_r);
    if (rnd_s > 64'(LIM)) rnd_o = 16'(LIM);
    else if (rnd_s < -64'(LIM)) rnd_o = 16'(-LIM);
    else rnd_o = rnd_s[15:0];
  end

  // divider result saturation
  logic [51:0] qsat;
  logic signed [39:0] qsig;
  logic signed [15:0] qout;
  always_comb begin
    qsat = (dq > 52'd32767) ? 52'd32767 : dq;
    qsig = p[idx][35] ? -40'(signed'({1'b0, qsat[38:0]})) : 40'(signed'({1'b0, qsat[38:0]}));
    if (qsig > LIM) qout = 16'(LIM);
    else if (qsig < -LIM) qout = 16'(-LIM);
    else qout = qsig[15:0];
  end

  logic signed [15:0] mtx [9];
  logic [6:0] dcnt;

  assign job_take  = (state == S_IDLE);
  assign empty     = !out_valid;
  assign row_index = row;
  assign col_a     = ma;
  assign col_b     = mb;
  assign col_c     = mc;
  assign rel       = held;
  assign held_flag = jb.held;
  assign last_row  = (row == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      held.w    <= 16'(LIM);
      held.x    <= 16'sd0;
      held.y    <= 16'sd0;
      held.z    <= 16'sd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            jb  <= job;
            idx <= 2'd0;
            tix <= 2'd0;
            cnt <= 6'd0;
            for (int i = 0; i < 4; i++) p[i] <= '0;
            state <= job.held ? S_MTX : S_PROD;
            mi  <= 4'd0;
            for (int i = 0; i < 9; i++) acc[i] <= 64'sd0;
          end
        end
        S_PROD: begin
          p[idx] <= tneg ? p[idx] - 36'(mul_r) : p[idx] + 36'(mul_r);
          tix <= tix + 2'd1;
          if (tix == 2'd3) begin
            idx <= idx + 2'd1;
            if (idx == 2'd3) state <= S_SHFT;
          end
        end
        S_SHFT: begin
          if (cnt == 6'd0) begin
            for (int i = 0; i < 4; i++) begin
              mag[i] <= p[i][35] ? 34'(-p[i]) : 34'(p[i]);
            end
            cnt <= 6'd1;
          end else if (mx >= (34'd1 << 30)) begin
            for (int i = 0; i < 4; i++) mag[i] <= mag[i] >> 1;
          end else begin
            n2    <= 64'd0;
            idx   <= 2'd0;
            cnt   <= 6'd0;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          n2  <= n2 + sq_out;
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            rem_s <= 64'd0;
            root  <= 32'd0;
            cnt   <= 6'd0;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (rem_sh >= 66'(trial)) begin
            rem_s <= 64'(rem_sh - 66'(trial));
            root  <= {root[30:0], 1'b1};
          end else begin
            rem_s <= rem_sh[63:0];
            root  <= {root[30:0], 1'b0};
          end
          n2  <= {n2[61:0], 2'b00};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            idx   <= 2'd0;
            dcnt  <= 7'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (root == 32'd0) begin
            held <= '0;
            state <= S_MTX;
          end else if (dcnt == 7'd0) begin
            dq   <= 52'(({18'd0, mag[idx]} << FRAC_BITS) + 52'(root >> 1));
            drem <= '0;
            dcnt <= 7'd1;
          end else if (dcnt <= 7'd52) begin
            if (dsh >= 66'(root)) begin
              drem <= dsh - 66'(root);
              dq   <= {dq[50:0], 1'b1};
            end else begin
              drem <= dsh;
              dq   <= {dq[50:0], 1'b0};
            end
            dcnt <= dcnt + 7'd1;
          end else begin
            unique case (idx)
              2'd0: held.w <= qout;
              2'd1: held.x <= qout;
              2'd2: held.y <= qout;
              default: held.z <= qout;
            endcase
            dcnt <= 7'd0;
            idx  <= idx + 2'd1;
            if (idx == 2'd3) begin
              mi    <= 4'd0;
              tix   <= 2'd0;
              state <= S_MTX;
            end
          end
        end
        S_MTX: begin
          acc[mi] <= msub ? acc[mi] - 64'(mul_r) : acc[mi] + 64'(mul_r);
          tix <= {1'b0, ~tix[0]};
          if (tix[0]) begin
            if (mi == 4'd8) begin
              mi    <= 4'd0;
              state <= S_ROW;
            end else begin
              mi <= mi + 4'd1;
            end
          end
        end
        S_ROW: begin
          // double, add the diagonal unity, round
          if (tix == 2'd0) begin
            for (int i = 0; i < 9; i++) begin
              acc[i] <= ((i == 0) || (i == 4) || (i == 8)) ?
                        ONE2 + (acc[i] <<< 1) : (acc[i] <<< 1);
            end
            tix <= 2'd1;
          end else begin
            mtx[mi] <= rnd_o;
            mi <= mi + 4'd1;
            if (mi == 4'd8) begin
              row   <= 2'd0;
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          ma <= mtx[{2'b00, row} * 4'd3];
          mb <= mtx[{2'b00, row} * 4'd3 + 4'd1];
          mc <= mtx[{2'b00, row} * 4'd3 + 4'd2];
          out_valid <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (pop) begin
            out_valid <= 1'b0;
            if (row == 2'd2) begin
              state <= S_IDLE;
            end else begin
              row   <= row + 2'd1;
              state <= S_OUT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/relative_quaternion_to_rotation.sv @@
// Relative quaternion to rotation matrix, top level: config registers, front, back.
// Depends on rqr_pkg, rqr_front, rqr_back.
// Each sample gives three row results. With ref_w nonzero the back sequencer
// works through 16 product terms, scaling, 4 squares, a bit-serial square root,
// four restoring divisions, 18 matrix products and the doubling and rounding of
// the matrix entries; a zero norm skips the divisions, and ref_w zero skips to
// the matrix products. Each row is then loaded and held until pop takes it. The
// front queue holds two samples, so up to two more can be pushed while the back
// works.
module relative_quaternion_to_rotation #(
  parameter int FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [15:0] cur_w,
  input  logic [15:0] cur_x,
  input  logic [15:0] cur_y,
  input  logic [15:0] cur_z,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  row_index,
  output logic [15:0] col_a,
  output logic [15:0] col_b,
  output logic [15:0] col_c,
  output logic [15:0] rel_w,
  output logic [15:0] rel_x,
  output logic [15:0] rel_y,
  output logic [15:0] rel_z,
  output logic        held_flag,
  output logic        last_row
);
  rqr_pkg::quat_t rf;
  rqr_pkg::quat_t cur;
  rqr_pkg::quat_t rel;
  rqr_pkg::job_t  job;
  logic           job_valid;
  logic           job_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      rf.w <= 16'sd16384;
      rf.x <= 16'sd0;
      rf.y <= 16'sd0;
      rf.z <= 16'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rqr_pkg::REG_W: rf.w <= cfg_data;
        rqr_pkg::REG_X: rf.x <= cfg_data;
        rqr_pkg::REG_Y: rf.y <= cfg_data;
        default:        rf.z <= cfg_data;
      endcase
    end
  end

  assign cur = '{w: cur_w, x: cur_x, y: cur_y, z: cur_z};

  rqr_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .cur(cur), .rf(rf),
    .job_valid(job_valid), .job_take(job_take), .job(job)
  );

  rqr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_take(job_take), .job(job),
    .empty(empty), .pop(pop), .row_index(row_index), .col_a(col_a),
    .col_b(col_b), .col_c(col_c), .rel(rel), .held_flag(held_flag),
    .last_row(last_row)
  );

  assign rel_w = rel.w;
  assign rel_x = rel.x;
  assign rel_y = rel.y;
  assign rel_z = rel.z;
endmodule
